// ----- hdl/asq_pkg.sv -----
// Shared types, codes and the aspect decoder for the signal aspect sequencer.
// Used by asq_channel, signal_aspect_sequencer and asq_checker; no dependencies.
package asq_pkg;

  // Input word: an aspect command or a one millisecond tick
  typedef struct packed {
    logic       req_type;
    logic [7:0] sig_letter;
    logic [7:0] main_char;
    logic [7:0] second_char;
  } req_t;

  // Result word
  typedef struct packed {
    logic [15:0] lamp_word;
    logic        cmd_error;
  } rsp_t;

  // Request kinds
  localparam logic REQ_CMD  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLANKING    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROPAGATION = 1'd1;
  localparam logic [15:0] BLANKING_RESET    = 16'd100;
  localparam logic [15:0] PROPAGATION_RESET = 16'd50;

  // Sequencer phases
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_CORE   = 2'd1,
    PH_SECOND = 2'd2,
    PH_THIRD  = 2'd3
  } phase_t;

  // Lamp codes and masks
  localparam logic [7:0] ASPECT_DARK  = 8'h40;
  localparam logic [7:0] SEC_CODE_0   = 8'h0c;
  localparam logic [7:0] SEC_CODE_1   = 8'h03;
  localparam logic [7:0] SEC_CODE_2   = 8'h0a;
  localparam logic [7:0] SEC_CODE_3   = 8'h0b;
  localparam logic [7:0] MAIN_CODE_1  = 8'h80;
  localparam logic [7:0] MAIN_CODE_2  = 8'ha0;
  localparam logic [7:0] MAIN_CODE_3  = 8'h90;
  localparam logic [7:0] MASK_CORE    = 8'hcc;
  localparam logic [7:0] MASK_SECOND  = 8'hfe;
  localparam logic [7:0] MASK_HIGH    = 8'hf0;
  localparam logic [7:0] MASK_LOW     = 8'h0f;

  // ASCII characters
  localparam logic [7:0] CHAR_A = 8'h61;
  localparam logic [7:0] CHAR_B = 8'h62;
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_1 = 8'h31;
  localparam logic [7:0] CHAR_2 = 8'h32;
  localparam logic [7:0] CHAR_3 = 8'h33;

  // Control from the top level to one signal channel
  typedef struct packed {
    logic       tick;
    logic       load;
    logic [7:0] aspect;
  } chan_ctl_t;

  // Decode two digits into {valid, aspect}; valid is low for a bad secondary digit
  function automatic logic [8:0] decode_aspect(input logic [7:0] main_c,
                                               input logic [7:0] sec_c);
    logic [7:0] code;
    logic       ok;
    ok = 1'b1;
    case (sec_c)
      CHAR_0:  code = SEC_CODE_0;
      CHAR_1:  code = SEC_CODE_1;
      CHAR_2:  code = SEC_CODE_2;
      CHAR_3:  code = SEC_CODE_3;
      default: begin
        code = SEC_CODE_0;
        ok   = 1'b0;
      end
    endcase
    case (main_c)
      CHAR_0:  code = ASPECT_DARK;
      CHAR_1:  code = code | MAIN_CODE_1;
      CHAR_2:  code = code | MAIN_CODE_2;
      CHAR_3:  code = code | MAIN_CODE_3;
      default: code = code;
    endcase
    return {ok, code};
  endfunction

endpackage

// ----- hdl/signal_aspect_sequencer.sv -----
// Top level of the signal aspect sequencer: input register, two channels, result register.
// Depends on asq_pkg and asq_channel.
//
// Drives two lamp signals on one 16-bit word, signal a on the low byte and signal b on
// the high byte. Each input word is either an aspect command (letter, main digit,
// secondary digit) or a one millisecond tick; each gives exactly one result word with
// the lamp word after it and an error flag for a rejected command. A new word is taken
// every clock cycle while the result side does not stall; a result passes through the input
// register and then the result register, with the channel update done in between.
// Blanking and propagation intervals are written through the configuration port; the user
// must write them only while the block is idle, which the block itself does not enforce.
module signal_aspect_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  asq_pkg::req_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output asq_pkg::rsp_t                 out_data,
  input  logic                          cfg_we,
  input  logic [asq_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [15:0]                   cfg_data
);
  import asq_pkg::*;

  logic        s0_valid;
  req_t        s0_data;
  logic        advance;
  logic [15:0] blanking_ticks;
  logic [15:0] propagation_ticks;
  logic [8:0]  decoded;
  logic        letter_a, letter_b, is_tick;
  chan_ctl_t   ctl_a, ctl_b;
  logic [7:0]  lamp_a_next, lamp_b_next;
  logic        cmd_error_next;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      blanking_ticks    <= BLANKING_RESET;
      propagation_ticks <= PROPAGATION_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_BLANKING:    blanking_ticks    <= cfg_data;
        CFG_PROPAGATION: propagation_ticks <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Handshake: move the held word on when the result register is free or being taken
  assign advance  = s0_valid && (!out_valid || out_ready);
  assign in_ready = !s0_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_ready) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_data <= in_data;
    end
  end

  // Decode the held word into channel controls
  always_comb begin
    decoded        = decode_aspect(s0_data.main_char, s0_data.second_char);
    is_tick        = s0_data.req_type == REQ_TICK;
    letter_a       = s0_data.sig_letter == CHAR_A;
    letter_b       = s0_data.sig_letter == CHAR_B;
    cmd_error_next = !is_tick && !((letter_a || letter_b) && decoded[8]);
    ctl_a.tick     = advance && is_tick;
    ctl_a.load     = advance && !is_tick && letter_a && decoded[8];
    ctl_a.aspect   = decoded[7:0];
    ctl_b.tick     = advance && is_tick;
    ctl_b.load     = advance && !is_tick && letter_b && decoded[8];
    ctl_b.aspect   = decoded[7:0];
  end

  asq_channel u_chan_a (
    .clk               (clk),
    .rst               (rst),
    .ctl               (ctl_a),
    .blanking_ticks    (blanking_ticks),
    .propagation_ticks (propagation_ticks),
    .lamp_next         (lamp_a_next)
  );

  asq_channel u_chan_b (
    .clk               (clk),
    .rst               (rst),
    .ctl               (ctl_b),
    .blanking_ticks    (blanking_ticks),
    .propagation_ticks (propagation_ticks),
    .lamp_next         (lamp_b_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.lamp_word <= {lamp_b_next, lamp_a_next};
      out_data.cmd_error <= cmd_error_next;
    end
  end

endmodule

// ----- hdl/asq_channel.sv -----
// One lamp signal: pending/shown aspect, four-phase sequencer, wait counter, lamp byte.
// Depends on asq_pkg.
module asq_channel (
  input  logic               clk,
  input  logic               rst,
  input  asq_pkg::chan_ctl_t ctl,
  input  logic [15:0]        blanking_ticks,
  input  logic [15:0]        propagation_ticks,
  output logic [7:0]         lamp_next
);
  import asq_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] wait_count, wait_count_next;
  logic [7:0]  shown, shown_next;
  logic [7:0]  pending, pending_next;
  logic [7:0]  lamp;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      wait_count <= '0;
      shown      <= ASPECT_DARK;
      pending    <= ASPECT_DARK;
      lamp       <= ASPECT_DARK;
    end else begin
      phase      <= phase_next;
      wait_count <= wait_count_next;
      shown      <= shown_next;
      pending    <= pending_next;
      lamp       <= lamp_next;
    end
  end

  // Next state: a command loads pending, a tick counts down or steps the phase
  always_comb begin
    phase_next      = phase;
    wait_count_next = wait_count;
    shown_next      = shown;
    pending_next    = pending;
    lamp_next       = lamp;
    if (ctl.load) begin
      pending_next = ctl.aspect;
    end
    if (ctl.tick) begin
      if (wait_count != '0) begin
        wait_count_next = wait_count - 16'd1;
      end else begin
        case (phase)
          PH_IDLE: begin
            if (pending != shown) begin
              // blank the whole byte when the main aspect changes
              if ((pending & MASK_HIGH) != (shown & MASK_HIGH)) begin
                lamp_next = '0;
              end else begin
                lamp_next = lamp & MASK_HIGH;
              end
              shown_next      = pending;
              phase_next      = PH_CORE;
              wait_count_next = blanking_ticks;
            end
          end
          PH_CORE: begin
            lamp_next       = lamp | (shown & MASK_CORE);
            phase_next      = PH_SECOND;
            wait_count_next = propagation_ticks;
          end
          PH_SECOND: begin
            lamp_next       = lamp | (shown & MASK_SECOND);
            phase_next      = PH_THIRD;
            wait_count_next = propagation_ticks;
          end
          default: begin
            lamp_next       = lamp | shown;
            phase_next      = PH_IDLE;
            wait_count_next = '0;
          end
        endcase
      end
    end
  end

endmodule

// ----- hdl/asq_checker.sv -----
// Port-level checks for signal_aspect_sequencer, attached by the bind at the end.
// Depends on asq_pkg.
module asq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input asq_pkg::req_t                 in_data,
  input logic                          out_valid,
  input logic                          out_ready,
  input asq_pkg::rsp_t                 out_data,
  input logic                          cfg_we,
  input logic [asq_pkg::CFG_IDX_W-1:0] cfg_idx,
  input logic [15:0]                   cfg_data
);
  import asq_pkg::*;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // The input side only stalls while a result word is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with no result waiting");

  // No result word right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

  // An empty block always takes a word
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input not ready with empty result register");

endmodule

bind signal_aspect_sequencer asq_checker u_asq_checker (.*);

// ----- sim/tb.sv -----
// Self-checking bench for signal_aspect_sequencer: drives commands and ticks with random gaps.
// It predicts each lamp word and error flag and checks the results in order.
// Depends on asq_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
  import asq_pkg::*;

  // Tracks both lamp sequencers and holds the lamp words still due from the block
  class lamp_tracker;
    logic [15:0] blank_len;
    logic [15:0] prop_len;
    logic [7:0]  shown[2];
    logic [7:0]  wanted[2];
    phase_t      stage[2];
    logic [15:0] countdown[2];
    logic [15:0] lamps;
    rsp_t        lamp_due[$];
    int          fails;

    function new();
      blank_len = BLANKING_RESET;
      prop_len  = PROPAGATION_RESET;
      for (int s = 0; s < 2; s++) begin
        shown[s]     = ASPECT_DARK;
        wanted[s]    = ASPECT_DARK;
        stage[s]     = PH_IDLE;
        countdown[s] = '0;
      end
      lamps = {ASPECT_DARK, ASPECT_DARK};
      fails = 0;
    endfunction

    function void set_intervals(logic [15:0] blank, logic [15:0] prop);
      blank_len = blank;
      prop_len  = prop;
    endfunction

    // Take one sequencer step for signal s once its wait has run out
    function void step_signal(int s);
      int          sh;
      logic [7:0]  lit;
      logic [15:0] clr;
      sh  = s * 8;
      lit = '0;
      case (stage[s])
        PH_IDLE: begin
          if (wanted[s] != shown[s]) begin
            // drop the whole byte on a main change, else only the secondary lamps
            if ((wanted[s] & MASK_HIGH) != (shown[s] & MASK_HIGH))
              clr = {8'h00, MASK_HIGH | MASK_LOW};
            else
              clr = {8'h00, MASK_LOW};
            lamps        = lamps & ~(clr << sh);
            shown[s]     = wanted[s];
            stage[s]     = PH_CORE;
            countdown[s] = blank_len;
          end
        end
        PH_CORE: begin
          lit          = shown[s] & MASK_CORE;
          stage[s]     = PH_SECOND;
          countdown[s] = prop_len;
        end
        PH_SECOND: begin
          lit          = shown[s] & MASK_SECOND;
          stage[s]     = PH_THIRD;
          countdown[s] = prop_len;
        end
        default: begin
          lit          = shown[s];
          stage[s]     = PH_IDLE;
          countdown[s] = '0;
        end
      endcase
      lamps = lamps | ({8'h00, lit} << sh);
    endfunction

    // Apply one accepted input word and queue the lamp word it leads to
    function void note_word(req_t w);
      rsp_t       r;
      int         s;
      logic [7:0] code;
      logic       ok;
      r.cmd_error = 1'b0;
      if (w.req_type == REQ_TICK) begin
        for (s = 0; s < 2; s++) begin
          if (countdown[s] != 0) countdown[s] = countdown[s] - 16'd1;
          else step_signal(s);
        end
      end else begin
        ok = 1'b1;
        s  = 0;
        if (w.sig_letter == CHAR_A) s = 0;
        else if (w.sig_letter == CHAR_B) s = 1;
        else ok = 1'b0;
        case (w.second_char)
          CHAR_0:  code = SEC_CODE_0;
          CHAR_1:  code = SEC_CODE_1;
          CHAR_2:  code = SEC_CODE_2;
          CHAR_3:  code = SEC_CODE_3;
          default: begin
            code = '0;
            ok   = 1'b0;
          end
        endcase
        // an unknown main digit leaves the secondary code alone
        case (w.main_char)
          CHAR_0:  code = ASPECT_DARK;
          CHAR_1:  code = code | MAIN_CODE_1;
          CHAR_2:  code = code | MAIN_CODE_2;
          CHAR_3:  code = code | MAIN_CODE_3;
          default: code = code;
        endcase
        if (ok) wanted[s] = code;
        else r.cmd_error = 1'b1;
      end
      r.lamp_word = lamps;
      lamp_due.push_back(r);
    endfunction

    // Compare one result word with the oldest lamp word due; keep the log bounded
    function void check_word(rsp_t got);
      rsp_t exp;
      if (lamp_due.size() == 0) begin
        if (fails < 200)
          $display("%0t unexpected result: lamp_word %h cmd_error %b",
                   $time, got.lamp_word, got.cmd_error);
        fails++;
      end else begin
        exp = lamp_due.pop_front();
        if (got.lamp_word !== exp.lamp_word) begin
          if (fails < 200)
            $display("%0t lamp_word mismatch: expected %h, actual %h",
                     $time, exp.lamp_word, got.lamp_word);
          fails++;
        end
        if (got.cmd_error !== exp.cmd_error) begin
          if (fails < 200)
            $display("%0t cmd_error mismatch: expected %b, actual %b",
                     $time, exp.cmd_error, got.cmd_error);
          fails++;
        end
      end
    endfunction

    function int waiting();
      return lamp_due.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  req_t                 in_data;
  logic                 out_valid;
  logic                 out_ready;
  rsp_t                 out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [15:0]          cfg_data;

  lamp_tracker board;
  int          lamps_seen;
  int          tx_calm;
  int          rx_calm;
  bit          held_off;

  signal_aspect_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("tb: FAIL");
    $finish;
  end

  // Mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic req_t make_word(logic kind, logic [7:0] letter, logic [7:0] main_c,
                                     logic [7:0] sec_c);
    req_t w;
    w.req_type    = kind;
    w.sig_letter  = letter;
    w.main_char   = main_c;
    w.second_char = sec_c;
    return w;
  endfunction

  // Mostly ticks and well-formed commands, some bad letters and digits, some noise
  function automatic req_t random_word();
    req_t w;
    int   r;
    r = $urandom_range(0, 99);
    w = make_word(REQ_CMD, 8'($urandom), 8'($urandom), 8'($urandom));
    if (r < 55) begin
      w.req_type = REQ_TICK;
    end else if (r < 88) begin
      w.sig_letter  = CHAR_A + 8'($urandom_range(0, 1));
      w.main_char   = CHAR_0 + 8'($urandom_range(0, 3));
      w.second_char = CHAR_0 + 8'($urandom_range(0, 3));
    end else if (r < 93) begin
      w.main_char   = CHAR_0 + 8'($urandom_range(0, 3));
      w.second_char = CHAR_0 + 8'($urandom_range(0, 3));
    end else if (r < 97) begin
      w.sig_letter  = CHAR_A + 8'($urandom_range(0, 1));
      w.second_char = CHAR_0 + 8'($urandom_range(0, 3));
    end
    return w;
  endfunction

  // Offer one word after a random gap and hold it until accepted
  task automatic send_word(input req_t w);
    int gap;
    if (tx_calm > 0) begin
      tx_calm--;
      gap = 0;
    end else begin
      gap = gap_len();
      if ($urandom_range(0, 49) == 0) tx_calm = $urandom_range(20, 80);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait until every lamp word due has come back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.waiting() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_intervals(input logic [15:0] blank, input logic [15:0] prop);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_BLANKING;
    cfg_data <= blank;
    @(negedge clk);
    cfg_idx  <= CFG_PROPAGATION;
    cfg_data <= prop;
    @(negedge clk);
    cfg_we   <= 1'b0;
    board.set_intervals(blank, prop);
  endtask

  // Note accepted words and check results at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.note_word(in_data);
      if (out_valid && out_ready) begin
        board.check_word(out_data);
        lamps_seen++;
      end
    end
  end

  // Result side: random stalls, calm stretches and one long hold-off
  initial begin : result_side
    int stall;
    out_ready = 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      if (!held_off && lamps_seen >= 620) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
      end else begin
        if (rx_calm > 0) begin
          rx_calm--;
          stall = 0;
        end else begin
          stall = gap_len();
          if ($urandom_range(0, 49) == 0) rx_calm = $urandom_range(20, 80);
        end
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        out_ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [15:0] blank;
    logic [15:0] prop;
    board      = new();
    lamps_seen = 0;
    tx_calm    = 0;
    rx_calm    = 0;
    held_off   = 1'b0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_idx    = '0;
    cfg_data   = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: zero intervals, full sequences, restarts and every rejection
    program_intervals(16'd0, 16'd0);
    send_word(make_word(REQ_CMD, CHAR_A, CHAR_1, CHAR_0));
    repeat (4) send_word(make_word(REQ_TICK, CHAR_A, CHAR_1, CHAR_0));
    send_word(make_word(REQ_CMD, CHAR_B, CHAR_3, CHAR_2));
    send_word(make_word(REQ_TICK, 8'h00, 8'h00, 8'h00));
    // new aspect while the old one is still being lit
    send_word(make_word(REQ_CMD, CHAR_B, CHAR_0, CHAR_1));
    repeat (5) send_word(make_word(REQ_TICK, 8'hff, 8'hff, 8'hff));
    // same main aspect: only the secondary lamps go dark
    send_word(make_word(REQ_CMD, CHAR_A, CHAR_1, CHAR_1));
    repeat (4) send_word(make_word(REQ_TICK, 8'h55, 8'haa, 8'h0f));
    send_word(make_word(REQ_CMD, 8'h00, CHAR_2, CHAR_3));
    send_word(make_word(REQ_CMD, 8'hff, CHAR_2, CHAR_3));
    send_word(make_word(REQ_CMD, CHAR_A, CHAR_2, 8'hff));
    send_word(make_word(REQ_CMD, CHAR_B, CHAR_1, 8'h00));
    // unknown main digit is taken without error
    send_word(make_word(REQ_CMD, CHAR_A, 8'hff, CHAR_3));
    send_word(make_word(REQ_CMD, CHAR_B, 8'h00, CHAR_0));
    send_word(make_word(REQ_TICK, 8'h00, 8'hff, 8'h00));

    // Random phases, each with its own intervals, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case (ph)
        0: begin blank = 16'd3;     prop = 16'd2;     end
        1: begin blank = 16'd0;     prop = 16'd0;     end
        2: begin blank = 16'hffff;  prop = 16'hffff;  end
        3: begin blank = 16'd0;     prop = 16'hffff;  end
        4: begin blank = 16'hffff;  prop = 16'd0;     end
        5: begin blank = 16'd1;     prop = 16'd1;     end
        default: begin
          blank = 16'($urandom_range(0, 8));
          prop  = 16'($urandom_range(0, 8));
        end
      endcase
      program_intervals(blank, prop);
      repeat (240) send_word(random_word());
    end

    settle();
    if (board.fails == 0 && board.waiting() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/asq_pkg.sv
hdl/asq_channel.sv
hdl/signal_aspect_sequencer.sv
hdl/asq_checker.sv
sim/tb.sv
